/* hdl/rans_interleaved_decoder_defines.svh */
// Assertion macros shared by the rANS decoder RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef RANS_INTERLEAVED_DECODER_DEFINES_SVH
`define RANS_INTERLEAVED_DECODER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RANS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RANS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/rans_dec_pkg.sv */
// Shared types and constants of the rANS decoder: operation codes, register
// indexes, FSM states, memory write bundles and the zigzag unmap function.
`timescale 1ns / 1ps

package rans_dec_pkg;

	typedef enum logic [1:0] {
		OP_LOAD_INFO = 2'd0,
		OP_LOAD_SLOT = 2'd1,
		OP_SET_LANE  = 2'd2,
		OP_DECODE    = 2'd3
	} op_t;

	localparam logic [1:0] CFG_CH_LOG2 = 2'd0;
	localparam logic [1:0] CFG_SIGNED  = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LANE,
		ST_SLOT,
		ST_INFO,
		ST_MUL
	} state_t;

	localparam int SLOT_ADDR_W = 18;
	localparam int INFO_ADDR_W = 10;
	localparam int LANE_COUNT  = 4;

	localparam logic [7:0] ZZ_MAG_MASK = 8'h7F;
	localparam logic [7:0] ZZ_MIN_NEG  = 8'h80;

	typedef struct packed {
		logic                   slot_we;
		logic [SLOT_ADDR_W-1:0] slot_addr;
		logic [7:0]             slot_data;
		logic                   info_we;
		logic [INFO_ADDR_W-1:0] info_addr;
		logic [15:0]            info_freq;
		logic [15:0]            info_start;
	} tbl_wr_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  addr;
		logic [31:0] data;
	} lane_wr_t;

	function automatic logic [7:0] zigzag_unmap(input logic [7:0] v);
		logic [7:0] m;
		m = (v >> 1) & ZZ_MAG_MASK;
		if (v[0]) begin
			m = 8'(8'd0 - m);
			if (m == 8'd0) begin
				m = ZZ_MIN_NEG;
			end
		end
		return m;
	endfunction

endpackage

/* hdl/rans_interleaved_decoder.sv */
// Four-lane interleaved rANS byte decoder with per-channel models.
// Depends on rans_dec_pkg, rans_dec_lane_mem, rans_dec_tables and the
// assertion macros in rans_interleaved_decoder_defines.svh.
//
// Usage:
//   Command channel: an item is taken at a rising edge with start high and
//   busy low. Table loads (operations 0 and 1) and set lane state (2) finish
//   at that edge and never raise busy or produce a result beat.
//   A decode (3) raises busy through the lane, slot, info and mul states:
//   lane state read, slot-table read, frequency/start read with the 16x16
//   multiply, then the update and write-back of the lane state. The result
//   beat (result_strobe with decoded_symbol and word_used) shows in the cycle
//   after the update, the first with busy low again; a new command may be
//   taken that same cycle. A new decode waits until the last one has written
//   back its lane state, as the reads through lane and table memories chain.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Write it only while no decode is in flight.
//   Reset clears the lane states, position, FSM and configuration registers; the table memories
//   hold garbage until loaded. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`include "rans_interleaved_decoder_defines.svh"

module rans_interleaved_decoder #(
	parameter int MAX_CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [1:0]  lane,
	input  logic [1:0]  channel,
	input  logic [7:0]  symbol,
	input  logic [15:0] slot,
	input  logic [15:0] freq,
	input  logic [15:0] cum_start,
	input  logic [31:0] state_value,
	input  logic [15:0] stream_word,
	output logic        result_strobe,
	output logic [7:0]  decoded_symbol,
	output logic        word_used,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);

	localparam logic [1:0] CH_LOG2_MAX = (MAX_CHANNELS >= 4) ? 2'd2 :
		(MAX_CHANNELS >= 2) ? 2'd1 : 2'd0;
	localparam logic [2:0] CH_LIMIT = 3'(MAX_CHANNELS);

	rans_dec_pkg::state_t state_q, state_d;

	logic [1:0]  ch_log2_q;
	logic        signed_q;
	logic [1:0]  pos_q;
	logic [1:0]  dec_lane_q;
	logic [1:0]  dec_chan_q;
	logic [15:0] word_q;
	logic [31:0] lane_state_q;
	logic [7:0]  sym_q;
	logic [31:0] prod_q;
	logic [15:0] start_q;
	logic        result_strobe_q;
	logic [7:0]  decoded_symbol_q;
	logic        word_used_q;

	logic        accept;
	logic        accept_dec;
	logic        ch_ok;
	logic [1:0]  eff_log2;
	logic [1:0]  ch_mask;
	logic        lane_rd_en;
	logic        slot_rd_en;
	logic        info_rd_en;
	logic [31:0] lane_rd_data;
	logic [7:0]  slot_rd_data;
	logic [15:0] info_freq;
	logic [15:0] info_start;
	logic [31:0] sum;
	logic        renorm;
	logic [31:0] new_state;

	rans_dec_pkg::tbl_wr_t  tbl_wr;
	rans_dec_pkg::lane_wr_t lane_wr;

	assign accept     = start && !busy;
	assign accept_dec = accept && (operation == rans_dec_pkg::OP_DECODE);
	assign ch_ok      = {1'b0, channel} < CH_LIMIT;
	assign cfg_ready  = 1'b1;

	// clamp the channel count to what the model stores hold
	assign eff_log2 = (ch_log2_q > CH_LOG2_MAX) ? CH_LOG2_MAX : ch_log2_q;
	assign ch_mask  = 2'((3'd1 << eff_log2) - 3'd1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rans_dec_pkg::ST_IDLE: begin
				if (accept_dec) begin
					state_d = rans_dec_pkg::ST_LANE;
				end
			end
			rans_dec_pkg::ST_LANE: state_d = rans_dec_pkg::ST_SLOT;
			rans_dec_pkg::ST_SLOT: state_d = rans_dec_pkg::ST_INFO;
			rans_dec_pkg::ST_INFO: state_d = rans_dec_pkg::ST_MUL;
			rans_dec_pkg::ST_MUL:  state_d = rans_dec_pkg::ST_IDLE;
			default:               state_d = rans_dec_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		busy       = 1'b1;
		lane_rd_en = 1'b0;
		slot_rd_en = 1'b0;
		info_rd_en = 1'b0;
		case (state_q)
			rans_dec_pkg::ST_IDLE: begin
				busy       = 1'b0;
				lane_rd_en = accept_dec;
			end
			rans_dec_pkg::ST_LANE: slot_rd_en = 1'b1;
			rans_dec_pkg::ST_SLOT: info_rd_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rans_dec_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_log2_q <= 2'd0;
			signed_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rans_dec_pkg::CFG_CH_LOG2: ch_log2_q <= cfg_data;
				rans_dec_pkg::CFG_SIGNED:  signed_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// position: cleared by a lane set, advanced by each decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (accept && (operation == rans_dec_pkg::OP_SET_LANE)) begin
			pos_q <= 2'd0;
		end else if (accept_dec) begin
			pos_q <= 2'(pos_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept_dec) begin
			dec_lane_q <= pos_q;
			dec_chan_q <= pos_q & ch_mask;
			word_q     <= stream_word;
		end
		if (state_q == rans_dec_pkg::ST_LANE) begin
			lane_state_q <= lane_rd_data;
		end
		if (state_q == rans_dec_pkg::ST_SLOT) begin
			sym_q <= slot_rd_data;
		end
		if (state_q == rans_dec_pkg::ST_INFO) begin
			prod_q  <= {16'd0, info_freq} * {16'd0, lane_state_q[31:16]};
			start_q <= info_start;
		end
	end

	assign sum       = prod_q + {16'd0, lane_state_q[15:0]} - {16'd0, start_q};
	assign renorm    = (sum[31:16] == 16'd0);
	assign new_state = renorm ? {sum[15:0], word_q} : sum;

	always_comb begin
		lane_wr      = '0;
		if (state_q == rans_dec_pkg::ST_MUL) begin
			lane_wr.we   = 1'b1;
			lane_wr.addr = dec_lane_q;
			lane_wr.data = new_state;
		end else if (accept && (operation == rans_dec_pkg::OP_SET_LANE)) begin
			lane_wr.we   = 1'b1;
			lane_wr.addr = lane;
			lane_wr.data = state_value;
		end
	end

	always_comb begin
		tbl_wr            = '0;
		tbl_wr.slot_we    = accept && ch_ok && (operation == rans_dec_pkg::OP_LOAD_SLOT);
		tbl_wr.slot_addr  = {channel, slot};
		tbl_wr.slot_data  = symbol;
		tbl_wr.info_we    = accept && ch_ok && (operation == rans_dec_pkg::OP_LOAD_INFO);
		tbl_wr.info_addr  = {channel, symbol};
		tbl_wr.info_freq  = freq;
		tbl_wr.info_start = cum_start;
	end

	rans_dec_lane_mem u_lane_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (lane_wr),
		.rd_en   (lane_rd_en),
		.rd_addr (pos_q),
		.rd_data (lane_rd_data)
	);

	rans_dec_tables #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_tables (
		.clk          (clk),
		.wr           (tbl_wr),
		.slot_rd_en   (slot_rd_en),
		.slot_rd_addr ({dec_chan_q, lane_rd_data[15:0]}),
		.slot_rd_data (slot_rd_data),
		.info_rd_en   (info_rd_en),
		.info_rd_addr ({dec_chan_q, slot_rd_data}),
		.info_freq    (info_freq),
		.info_start   (info_start)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= (state_q == rans_dec_pkg::ST_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rans_dec_pkg::ST_MUL) begin
			decoded_symbol_q <= signed_q ? rans_dec_pkg::zigzag_unmap(sym_q) : sym_q;
			word_used_q      <= renorm;
		end
	end

	assign result_strobe  = result_strobe_q;
	assign decoded_symbol = decoded_symbol_q;
	assign word_used      = word_used_q;

	`RANS_ASSERT_NEXT(a_dec_starts, clk, arst_n, accept_dec,
		state_q == rans_dec_pkg::ST_LANE, "decode accept did not start the lane read")
	`RANS_ASSERT_NEXT(a_mul_strobes, clk, arst_n, state_q == rans_dec_pkg::ST_MUL,
		result_strobe && !busy, "update cycle not followed by a result beat")
	`RANS_ASSERT_NOW(a_strobe_src, clk, arst_n, result_strobe,
		$past(state_q) == rans_dec_pkg::ST_MUL, "result beat without an update cycle")
	`RANS_ASSERT_NEXT(a_pos_step, clk, arst_n, accept_dec,
		pos_q == 2'($past(pos_q) + 2'd1), "position did not advance on decode")

endmodule

/* hdl/rans_dec_lane_mem.sv */
// Lane state store of the rANS decoder: four 32-bit entries, one write and
// one registered read port; per-entry valid bits make unwritten lanes read 0.
`timescale 1ns / 1ps

module rans_dec_lane_mem (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rans_dec_pkg::lane_wr_t wr,
	input  logic                   rd_en,
	input  logic [1:0]             rd_addr,
	output logic [31:0]            rd_data
);

	logic [31:0] mem [rans_dec_pkg::LANE_COUNT];
	logic [rans_dec_pkg::LANE_COUNT-1:0] vld_q;
	logic [31:0] rd_data_q;
	logic        rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.we) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// a lane never written since reset holds zero
	assign rd_data = rd_vld_q ? rd_data_q : 32'd0;

endmodule

/* hdl/rans_dec_tables.sv */
// Model tables of the rANS decoder: slot-to-symbol memory and the packed
// frequency/start memory, each one write port and one registered read port.
`timescale 1ns / 1ps

module rans_dec_tables #(
	parameter int MAX_CHANNELS = 4
) (
	input  logic                                 clk,
	input  rans_dec_pkg::tbl_wr_t                wr,
	input  logic                                 slot_rd_en,
	input  logic [rans_dec_pkg::SLOT_ADDR_W-1:0] slot_rd_addr,
	output logic [7:0]                           slot_rd_data,
	input  logic                                 info_rd_en,
	input  logic [rans_dec_pkg::INFO_ADDR_W-1:0] info_rd_addr,
	output logic [15:0]                          info_freq,
	output logic [15:0]                          info_start
);

	localparam int SLOT_DEPTH = MAX_CHANNELS * 65536;
	localparam int INFO_DEPTH = MAX_CHANNELS * 256;
	localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
	localparam int INFO_AW    = $clog2(INFO_DEPTH);

	logic [7:0]  slot_mem [SLOT_DEPTH];
	logic [31:0] info_mem [INFO_DEPTH];
	logic [7:0]  slot_rd_q;
	logic [31:0] info_rd_q;

	always_ff @(posedge clk) begin
		if (wr.slot_we) begin
			slot_mem[wr.slot_addr[SLOT_AW-1:0]] <= wr.slot_data;
		end
		if (slot_rd_en) begin
			slot_rd_q <= slot_mem[slot_rd_addr[SLOT_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.info_we) begin
			info_mem[wr.info_addr[INFO_AW-1:0]] <= {wr.info_freq, wr.info_start};
		end
		if (info_rd_en) begin
			info_rd_q <= info_mem[info_rd_addr[INFO_AW-1:0]];
		end
	end

	assign slot_rd_data = slot_rd_q;
	assign info_freq    = info_rd_q[31:16];
	assign info_start   = info_rd_q[15:0];

endmodule
